// ===== hdl/poct_pkg.sv =====
// ----------------------------------------------------------------------------
// poct_pkg
// Shared widths, defaults and types for the priority scheduling block.
// ----------------------------------------------------------------------------
package poct_pkg;

	// default batch capacity
	localparam int MAX_JOBS_DEF = 16;

	// fixed field widths
	localparam int BURST_W = 16;
	localparam int PRI_W   = 8;
	localparam int NUM_W   = 4;
	localparam int TIME_W  = 20;

	localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

	// sequencer states
	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_READ  = 5'b00010,
		S_CMP   = 5'b00100,
		S_EMIT  = 5'b01000,
		S_DRAIN = 5'b10000
	} state_t;

	// emit control aligned with the store read data
	typedef struct packed {
		logic valid;
		logic last;
	} emit_t;

endpackage

// ===== hdl/priority_order_completion_times.sv =====
// ----------------------------------------------------------------------------
// priority_order_completion_times
// Non-preemptive priority scheduler: loads a batch of jobs, keeps them
// sorted by priority (stable, highest first) and emits completion times.
// ----------------------------------------------------------------------------
//
//  channel   ports                                           handshake
//  -------   ---------------------------------------------   -------------------
//  job in    burst_time, job_priority, batch_end             start & !busy
//  result    job_number, job_burst, job_level,               result_valid, one
//            completion_time, final_result                   cycle, no stall
//
//  Each job is inserted into the sorted store as it arrives, moving past
//  the stored jobs of lower priority one at a time, landing at the head if
//  it passes them all; each step is one store read and one compare in the
//  shared comparator.
//  A closing job keeps busy high while the n results are swept out, one
//  per cycle, and through the drain state; the last strobe shows in the
//  first cycle with busy low.
//  Reset clears the sequencer, job count and running sum; the store is not
//  cleared. The receiver cannot stall results.
//
module priority_order_completion_times
	import poct_pkg::*;
#(
	parameter int MAX_JOBS = MAX_JOBS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [BURST_W-1:0] burst_time,
	input  logic [PRI_W-1:0]   job_priority,
	input  logic               batch_end,
	output logic               result_valid,
	output logic [NUM_W-1:0]   job_number,
	output logic [BURST_W-1:0] job_burst,
	output logic [PRI_W-1:0]   job_level,
	output logic [TIME_W-1:0]  completion_time,
	output logic               final_result
);

	localparam int IDX_W = $clog2(MAX_JOBS);
	localparam int DW    = IDX_W + PRI_W + BURST_W;

	logic             we;
	logic [IDX_W-1:0] waddr;
	logic [DW-1:0]    wdata;
	logic [IDX_W-1:0] raddr;
	logic [DW-1:0]    rdata;
	emit_t            emit_s1;

	// sequencer and shared compare
	poct_ctrl #(
		.MAX_JOBS (MAX_JOBS),
		.IDX_W    (IDX_W),
		.DW       (DW)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.burst_time   (burst_time),
		.job_priority (job_priority),
		.batch_end    (batch_end),
		.we           (we),
		.waddr        (waddr),
		.wdata        (wdata),
		.raddr        (raddr),
		.rdata        (rdata),
		.emit_s1      (emit_s1)
	);

	// sorted job store
	poct_ram #(
		.DEPTH (MAX_JOBS),
		.AW    (IDX_W),
		.DW    (DW)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	// completion time and result stage
	poct_acc #(
		.IDX_W (IDX_W)
	) u_acc (
		.clk             (clk),
		.arst_n          (arst_n),
		.emit_s1         (emit_s1),
		.rd_num          (rdata[BURST_W+PRI_W +: IDX_W]),
		.rd_burst        (rdata[BURST_W-1:0]),
		.rd_pri          (rdata[BURST_W +: PRI_W]),
		.result_valid    (result_valid),
		.job_number      (job_number),
		.job_burst       (job_burst),
		.job_level       (job_level),
		.completion_time (completion_time),
		.final_result    (final_result)
	);

endmodule

// ===== hdl/poct_ram.sv =====
// ----------------------------------------------------------------------------
// poct_ram
// Job store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module poct_ram #(
	parameter int DEPTH = 16,
	parameter int AW    = 4,
	parameter int DW    = 28
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

// ===== hdl/poct_ctrl.sv =====
// ----------------------------------------------------------------------------
// poct_ctrl
// Sequencer: insertion of each job into the sorted store through one
// shared priority compare, then an in-order read sweep of the batch.
// ----------------------------------------------------------------------------
module poct_ctrl
	import poct_pkg::*;
#(
	parameter int MAX_JOBS = MAX_JOBS_DEF,
	parameter int IDX_W    = $clog2(MAX_JOBS),
	parameter int DW       = IDX_W + PRI_W + BURST_W
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [BURST_W-1:0] burst_time,
	input  logic [PRI_W-1:0]   job_priority,
	input  logic               batch_end,
	output logic               we,
	output logic [IDX_W-1:0]   waddr,
	output logic [DW-1:0]      wdata,
	output logic [IDX_W-1:0]   raddr,
	input  logic [DW-1:0]      rdata,
	output emit_t              emit_s1
);

	localparam int CNT_W = $clog2(MAX_JOBS + 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_JOBS);

	state_t             state_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [IDX_W-1:0]   k_q;
	logic [IDX_W-1:0]   e_q;
	logic [IDX_W-1:0]   last_q;
	logic [BURST_W-1:0] burst_q;
	logic [PRI_W-1:0]   pri_q;
	logic [IDX_W-1:0]   num_q;
	logic               end_q;

	logic [CNT_W-1:0]   cnt_inc;
	logic               closes;
	logic [PRI_W-1:0]   rd_pri;
	logic               displace;

	assign busy     = (state_q != S_IDLE);
	assign cnt_inc  = cnt_q + CNT_W'(1);
	assign closes   = end_q || (cnt_inc == CNT_FULL);
	assign rd_pri   = rdata[BURST_W +: PRI_W];
	// shared compare: stored entry has strictly lower priority, so it moves down
	assign displace = (rd_pri < pri_q);

	// store port steering
	always_comb begin
		we    = 1'b0;
		waddr = k_q;
		wdata = {num_q, pri_q, burst_q};
		raddr = e_q;
		case (state_q)
			S_READ: begin
				raddr = k_q - IDX_W'(1);
				if (k_q == '0) begin
					we = 1'b1;
				end
			end
			S_CMP: begin
				we = 1'b1;
				if (displace) begin
					wdata = rdata;
				end
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			k_q     <= '0;
			e_q     <= '0;
			last_q  <= '0;
			emit_s1 <= '0;
		end else begin
			// emit control is registered and follows the sweep in the next cycle
			emit_s1.valid <= (state_q == S_EMIT);
			emit_s1.last  <= (state_q == S_EMIT) && (e_q == last_q);
			case (state_q)
				S_IDLE: begin
					if (start) begin
						k_q     <= cnt_q[IDX_W-1:0];
						state_q <= S_READ;
					end
				end
				S_READ: begin
					if (k_q == '0) begin
						cnt_q  <= cnt_inc;
						last_q <= cnt_q[IDX_W-1:0];
						e_q    <= '0;
						state_q <= closes ? S_EMIT : S_IDLE;
					end else begin
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					if (displace) begin
						k_q     <= k_q - IDX_W'(1);
						state_q <= S_READ;
					end else begin
						cnt_q  <= cnt_inc;
						last_q <= cnt_q[IDX_W-1:0];
						e_q    <= '0;
						state_q <= closes ? S_EMIT : S_IDLE;
					end
				end
				S_EMIT: begin
					e_q <= e_q + IDX_W'(1);
					if (e_q == last_q) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					cnt_q   <= '0;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// captured job
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			burst_q <= burst_time;
			pri_q   <= job_priority;
			num_q   <= cnt_q[IDX_W-1:0];
			end_q   <= batch_end;
		end
	end

endmodule

// ===== hdl/poct_acc.sv =====
// ----------------------------------------------------------------------------
// poct_acc
// Completion time accumulator and result register stage.
// ----------------------------------------------------------------------------
module poct_acc
	import poct_pkg::*;
#(
	parameter int IDX_W = $clog2(MAX_JOBS_DEF)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  emit_t              emit_s1,
	input  logic [IDX_W-1:0]   rd_num,
	input  logic [BURST_W-1:0] rd_burst,
	input  logic [PRI_W-1:0]   rd_pri,
	output logic               result_valid,
	output logic [NUM_W-1:0]   job_number,
	output logic [BURST_W-1:0] job_burst,
	output logic [PRI_W-1:0]   job_level,
	output logic [TIME_W-1:0]  completion_time,
	output logic               final_result
);

	localparam int EXT_W = (IDX_W > NUM_W) ? IDX_W : NUM_W;

	logic [TIME_W-1:0] sum_q;
	logic [TIME_W:0]   sum_wide;
	logic [TIME_W-1:0] sum_sat;
	logic [EXT_W-1:0]  num_ext;

	// saturating running sum
	assign sum_wide = {1'b0, sum_q} + (TIME_W+1)'(rd_burst);
	assign sum_sat  = sum_wide[TIME_W] ? TIME_MAX : sum_wide[TIME_W-1:0];
	assign num_ext  = EXT_W'(rd_num);

	// control: strobe and sum, cleared after the last result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
			sum_q        <= '0;
		end else begin
			result_valid <= emit_s1.valid;
			if (emit_s1.valid) begin
				sum_q <= emit_s1.last ? '0 : sum_sat;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (emit_s1.valid) begin
			job_number      <= num_ext[NUM_W-1:0];
			job_burst       <= rd_burst;
			job_level       <= rd_pri;
			completion_time <= sum_sat;
			final_result    <= emit_s1.last;
		end
	end

endmodule
